// File: src/id3w_pkg.sv
package id3w_pkg;

   // Largest tag size width; the tag size field is four 7-bit groups
   localparam int TagSizeBitsDef = 28;

   localparam int HdrLen = 10;

   localparam logic [7:0] PfxByte0 = 8'h49;  // 'I'
   localparam logic [7:0] PfxByte1 = 8'h44;  // 'D'
   localparam logic [7:0] PfxByte2 = 8'h33;  // '3'
   localparam logic [7:0] VerV23   = 8'h03;
   localparam logic [7:0] VerV24   = 8'h04;

   localparam logic [31:0] IdTitle   = 32'h5449_5432;  // TIT2
   localparam logic [31:0] IdArtist  = 32'h5450_4531;  // TPE1
   localparam logic [31:0] IdStation = 32'h5452_534E;  // TRSN

   typedef enum logic [2:0] {
      PH_TAG_HDR   = 3'd0,
      PH_FRAME_HDR = 3'd1,
      PH_PAYLOAD   = 3'd2,
      PH_DONE      = 3'd3,
      PH_BAD       = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_TITLE   = 2'd1,
      KIND_ARTIST  = 2'd2,
      KIND_STATION = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NO_HDR    = 2'd1,
      STAT_BAD_VER   = 2'd2,
      STAT_TRUNCATED = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       payload_valid;
      kind_type   frame_kind;
      logic       frame_first;
      logic       frame_last;
      logic       packet_done;
      status_type status;
   } rsp_type;

endpackage

// File: src/id3w_step.sv
module id3w_step
   import id3w_pkg::*;
#(
   parameter int TAG_SIZE_BITS = TagSizeBitsDef
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_fire,
   input  logic [7:0] data_byte,
   input  logic       packet_last,
   output rsp_type    result
);

   localparam int Tw = TAG_SIZE_BITS;

   phase_type      phase_ff,   phase_in;
   logic [3:0]     fcnt_ff,    fcnt_in;
   logic           v24_ff,     v24_in;
   logic [Tw-1:0]  tag_ff,     tag_in;
   logic           tag_ovf_ff, tag_ovf_in;
   logic [31:0]    fid_ff,     fid_in;
   logic [31:0]    frem_ff,    frem_in;
   kind_type       kind_ff,    kind_in;
   status_type     err_ff,     err_in;

   logic [Tw+6:0]  tag_wide;
   logic [Tw-1:0]  tag_dec;
   logic           hdr_pending;

   always_comb begin
      phase_in   = phase_ff;
      fcnt_in    = fcnt_ff;
      v24_in     = v24_ff;
      tag_in     = tag_ff;
      tag_ovf_in = tag_ovf_ff;
      fid_in     = fid_ff;
      frem_in    = frem_ff;
      kind_in    = kind_ff;
      err_in     = err_ff;
      tag_wide   = {tag_ff, data_byte[6:0]};
      tag_dec    = (tag_ff != '0) ? tag_ff - Tw'(1) : tag_ff;

      unique case (phase_ff)
         PH_TAG_HDR: begin
            if (fcnt_ff == 4'd0 && data_byte != PfxByte0) begin
               err_in   = STAT_NO_HDR;
               phase_in = PH_BAD;
            end else if (fcnt_ff == 4'd1 && data_byte != PfxByte1) begin
               err_in   = STAT_NO_HDR;
               phase_in = PH_BAD;
            end else if (fcnt_ff == 4'd2 && data_byte != PfxByte2) begin
               err_in   = STAT_NO_HDR;
               phase_in = PH_BAD;
            end else if (fcnt_ff == 4'd3) begin
               if (data_byte == VerV23) begin
                  v24_in = 1'b0;
               end else if (data_byte == VerV24) begin
                  v24_in = 1'b1;
               end else begin
                  err_in   = STAT_BAD_VER;
                  phase_in = PH_BAD;
               end
            end else if (fcnt_ff >= 4'd6) begin
               // bits pushed past the size width mean the size saturates
               tag_in     = tag_wide[Tw-1:0];
               tag_ovf_in = tag_ovf_ff | (|tag_wide[Tw+6:Tw]);
            end
            fcnt_in = fcnt_ff + 4'd1;
            if (phase_in == PH_TAG_HDR && fcnt_in >= 4'(HdrLen)) begin
               if (tag_ovf_in) tag_in = '1;
               fcnt_in  = '0;
               fid_in   = '0;
               frem_in  = '0;
               kind_in  = KIND_NONE;
               phase_in = (tag_in >= Tw'(HdrLen)) ? PH_FRAME_HDR : PH_DONE;
            end
         end
         PH_BAD: begin
            if (fcnt_ff < 4'(HdrLen)) fcnt_in = fcnt_ff + 4'd1;
         end
         PH_FRAME_HDR: begin
            if (fcnt_ff < 4'd4) begin
               fid_in = {fid_ff[23:0], data_byte};
            end else if (fcnt_ff < 4'd8) begin
               frem_in = v24_ff ? {frem_ff[24:0], data_byte[6:0]}
                                : {frem_ff[23:0], data_byte};
            end
            tag_in  = tag_dec;
            fcnt_in = fcnt_ff + 4'd1;
            if (fcnt_in >= 4'(HdrLen)) begin
               if (fid_in == '0 || frem_in == '0 || frem_in > 32'(tag_in)) begin
                  phase_in = PH_DONE;
               end else begin
                  if (fid_in == IdTitle)        kind_in = KIND_TITLE;
                  else if (fid_in == IdArtist)  kind_in = KIND_ARTIST;
                  else if (fid_in == IdStation) kind_in = KIND_STATION;
                  else                          kind_in = KIND_NONE;
                  fcnt_in  = '0;
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            fcnt_in = 4'd1;
            tag_in  = tag_dec;
            if (frem_ff != '0) frem_in = frem_ff - 32'd1;
            if (frem_in == '0) begin
               fcnt_in  = '0;
               fid_in   = '0;
               kind_in  = KIND_NONE;
               phase_in = (tag_in >= Tw'(HdrLen)) ? PH_FRAME_HDR : PH_DONE;
            end
         end
         default: begin
         end
      endcase
   end

   // Copy payload of selected frames; report status on the packet's last byte
   always_comb begin
      result      = '0;
      hdr_pending = (phase_in == PH_TAG_HDR) ||
                    (phase_in == PH_BAD && fcnt_in < 4'(HdrLen));

      if (phase_ff == PH_PAYLOAD && kind_ff != KIND_NONE) begin
         result.payload_byte  = data_byte;
         result.payload_valid = 1'b1;
         result.frame_kind    = kind_ff;
         result.frame_first   = (fcnt_ff == 4'd0);
         result.frame_last    = (frem_ff == 32'd1);
      end

      result.packet_done = packet_last;
      if (packet_last) begin
         if (hdr_pending)                               result.status = STAT_NO_HDR;
         else if (err_in != STAT_OK)                    result.status = err_in;
         else if (phase_in == PH_PAYLOAD && frem_in != '0) result.status = STAT_TRUNCATED;
         else                                           result.status = STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (in_fire && packet_last)) begin
         phase_ff   <= PH_TAG_HDR;
         fcnt_ff    <= '0;
         v24_ff     <= 1'b0;
         tag_ff     <= '0;
         tag_ovf_ff <= 1'b0;
         fid_ff     <= '0;
         frem_ff    <= '0;
         kind_ff    <= KIND_NONE;
         err_ff     <= STAT_OK;
      end else if (in_fire) begin
         phase_ff   <= phase_in;
         fcnt_ff    <= fcnt_in;
         v24_ff     <= v24_in;
         tag_ff     <= tag_in;
         tag_ovf_ff <= tag_ovf_in;
         fid_ff     <= fid_in;
         frem_ff    <= frem_in;
         kind_ff    <= kind_in;
         err_ff     <= err_in;
      end
   end

endmodule

// File: src/id3_timed_frame_walker.sv
// Channel   Dir  Ports                    Contents
// req       in   req_tvalid/tready/tdata  one packet byte; tlast = final byte of packet
// rsp       out  rsp_tvalid/tready/tdata  one result per request; tlast = packet done
//                rsp_tuser                payload marks (valid, kind, first, last)
//
// A request can be taken every cycle unless the output buffer is full. The
// parser state advances in the accept cycle, and the result lands in a
// two-entry output buffer (main register plus skid register). req_tready
// drops only while both output entries hold results.
// Reset is synchronous, active high; all parser state also returns to its
// reset values after the request that carries tlast.
module id3_timed_frame_walker
   import id3w_pkg::*;
#(
   parameter int TAG_SIZE_BITS = TagSizeBitsDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // packet_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] payload_byte, [9:8] status, [15:10] zero
   output logic [4:0]  rsp_tuser,   // [0] payload_valid, [2:1] frame_kind,
                                    // [3] frame_first, [4] frame_last
   output logic        rsp_tlast    // packet_done
);

   rsp_type step_rsp;
   rsp_type main_ff,  main_in;
   rsp_type skid_ff,  skid_in;
   logic    main_vld_ff, main_vld_in;
   logic    skid_vld_ff, skid_vld_in;
   logic    in_fire, out_fire;

   // Accept a request whenever the skid entry is free
   assign req_tready = !skid_vld_ff;
   assign in_fire    = req_tvalid && req_tready;
   assign out_fire   = main_vld_ff && rsp_tready;

   // Walk the tag one byte per accepted request
   id3w_step #(
      .TAG_SIZE_BITS(TAG_SIZE_BITS)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .in_fire    (in_fire),
      .data_byte  (req_tdata),
      .packet_last(req_tlast),
      .result     (step_rsp)
   );

   always_comb begin
      main_in     = main_ff;
      main_vld_in = main_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;

      // Refill the main entry when it is empty or drains this cycle:
      // the skid entry goes first, then a fresh result
      if (!main_vld_ff || out_fire) begin
         if (skid_vld_ff) begin
            main_in     = skid_ff;
            main_vld_in = 1'b1;
            skid_vld_in = 1'b0;
         end else if (in_fire) begin
            main_in     = step_rsp;
            main_vld_in = 1'b1;
         end else begin
            main_vld_in = 1'b0;
         end
      end else if (in_fire) begin
         // Main entry stalled: park the new result in the skid entry
         skid_in     = step_rsp;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         main_vld_ff <= main_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = main_vld_ff;
   assign rsp_tdata  = {6'd0, main_ff.status, main_ff.payload_byte};
   assign rsp_tuser  = {main_ff.frame_last, main_ff.frame_first, main_ff.frame_kind,
                        main_ff.payload_valid};
   assign rsp_tlast  = main_ff.packet_done;

endmodule

// File: tb/id3_timed_frame_walker_checker.sv
module id3_timed_frame_walker_checker
   import id3w_pkg::*;
#(
   parameter int TAG_SIZE_BITS = TagSizeBitsDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic [4:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          owed,
   output int          fails
);

   localparam logic [31:0] TagMax = (32'd1 << TAG_SIZE_BITS) - 32'd1;

   // predicted walker state
   phase_type   ph;
   logic [3:0]  fcount;
   logic        v24;
   logic [31:0] tag_left;
   logic [31:0] id_shift;
   logic [31:0] frame_left;
   kind_type    cur_kind;
   status_type  err;

   rsp_type     walk_q[$];
   int          errs = 0;

   function automatic void clear_walk();
      ph         = PH_TAG_HDR;
      fcount     = '0;
      v24        = 1'b0;
      tag_left   = '0;
      id_shift   = '0;
      frame_left = '0;
      cur_kind   = KIND_NONE;
      err        = STAT_OK;
   endfunction

   function automatic void begin_frames();
      fcount     = '0;
      id_shift   = '0;
      frame_left = '0;
      cur_kind   = KIND_NONE;
      ph         = (tag_left >= HdrLen) ? PH_FRAME_HDR : PH_DONE;
   endfunction

   function automatic rsp_type walk_byte(input logic [7:0] b, input logic last);
      rsp_type    r;
      logic [3:0] i;
      logic       hdr_done;
      r = '0;
      i = fcount;
      case (ph)
         PH_TAG_HDR: begin
            if (i == 0 && b != PfxByte0) begin
               err = STAT_NO_HDR;
               ph  = PH_BAD;
            end else if (i == 1 && b != PfxByte1) begin
               err = STAT_NO_HDR;
               ph  = PH_BAD;
            end else if (i == 2 && b != PfxByte2) begin
               err = STAT_NO_HDR;
               ph  = PH_BAD;
            end else if (i == 3) begin
               if (b == VerV23) v24 = 1'b0;
               else if (b == VerV24) v24 = 1'b1;
               else begin
                  err = STAT_BAD_VER;
                  ph  = PH_BAD;
               end
            end else if (i >= 6) begin
               tag_left = ({tag_left[24:0], b[6:0]}) & 32'h0FFF_FFFF;
            end
            fcount = fcount + 4'd1;
            if (ph == PH_TAG_HDR && fcount >= HdrLen) begin
               if (tag_left > TagMax) tag_left = TagMax;
               begin_frames();
            end
         end
         PH_BAD: begin
            if (fcount < HdrLen) fcount = fcount + 4'd1;
         end
         PH_FRAME_HDR: begin
            if (i < 4) id_shift = {id_shift[23:0], b};
            else if (i < 8) begin
               if (v24) frame_left = {frame_left[24:0], b[6:0]};
               else frame_left = {frame_left[23:0], b};
            end
            if (tag_left > 0) tag_left = tag_left - 32'd1;
            fcount = fcount + 4'd1;
            if (fcount >= HdrLen) begin
               if (id_shift == '0 || frame_left == '0 || frame_left > tag_left) begin
                  ph = PH_DONE;
               end else begin
                  if (id_shift == IdTitle) cur_kind = KIND_TITLE;
                  else if (id_shift == IdArtist) cur_kind = KIND_ARTIST;
                  else if (id_shift == IdStation) cur_kind = KIND_STATION;
                  else cur_kind = KIND_NONE;
                  fcount = '0;
                  ph     = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            if (cur_kind != KIND_NONE) begin
               r.payload_byte  = b;
               r.payload_valid = 1'b1;
               r.frame_kind    = cur_kind;
               r.frame_first   = (fcount == 0);
               r.frame_last    = (frame_left == 32'd1);
            end
            fcount = 4'd1;
            if (tag_left > 0) tag_left = tag_left - 32'd1;
            if (frame_left > 0) frame_left = frame_left - 32'd1;
            if (frame_left == 0) begin_frames();
         end
         default: ;
      endcase

      hdr_done = !(ph == PH_TAG_HDR || (ph == PH_BAD && fcount < HdrLen));
      r.packet_done = last;
      if (last) begin
         if (!hdr_done) r.status = STAT_NO_HDR;
         else if (err != STAT_OK) r.status = err;
         else if (ph == PH_PAYLOAD && frame_left > 0) r.status = STAT_TRUNCATED;
         else r.status = STAT_OK;
         clear_walk();
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         errs++;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         clear_walk();
         walk_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (walk_q.size() == 0) begin
               $error("result with no request outstanding");
               errs++;
            end else begin
               want = walk_q.pop_front();
               check_field("payload_byte", 32'(want.payload_byte), 32'(rsp_tdata[7:0]));
               check_field("status", 32'(want.status), 32'(rsp_tdata[9:8]));
               check_field("tdata_pad", 32'd0, 32'(rsp_tdata[15:10]));
               check_field("payload_valid", 32'(want.payload_valid), 32'(rsp_tuser[0]));
               check_field("frame_kind", 32'(want.frame_kind), 32'(rsp_tuser[2:1]));
               check_field("frame_first", 32'(want.frame_first), 32'(rsp_tuser[3]));
               check_field("frame_last", 32'(want.frame_last), 32'(rsp_tuser[4]));
               check_field("packet_done", 32'(want.packet_done), 32'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) walk_q.push_back(walk_byte(req_tdata, req_tlast));
      end
      owed  <= walk_q.size();
      fails <= errs;
   end

endmodule

// File: tb/id3_timed_frame_walker_tb.sv
module id3_timed_frame_walker_tb
   import id3w_pkg::*;
();

   localparam int RandomBytes = 750;
   localparam int QuietBytes  = 200;     // final stretch with no idling
   localparam int CycleLimit  = 400000;
   localparam int DrainCycles = 20;
   localparam int HoldStart   = 400;     // receiver cycle at which the long stall begins
   localparam int HoldCycles  = 300;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] data_byte
   logic        req_tlast  = 1'b0; // packet_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [7:0] payload_byte, [9:8] status, [15:10] zero
   logic [4:0]  rsp_tuser;         // [0] payload_valid, [2:1] frame_kind,
                                   // [3] frame_first, [4] frame_last
   logic        rsp_tlast;         // packet_done

   int          owed;
   int          fails;

   logic [7:0]  pkt_q[$];          // bytes of the packet under construction
   int          bytes_sent = 0;
   logic        quiet = 1'b0;      // set for the final stretch: no idling on either side
   int          cycle_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   id3_timed_frame_walker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   id3_timed_frame_walker_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .owed       (owed),
      .fails      (fails)
   );

   // Offer one request; optionally drop valid for a random burst first,
   // then hold the request until the block takes it.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (!quiet && $urandom_range(0, 6) == 0) begin
         gap = $urandom_range(1, 18);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // Send the built packet, or only its first keep bytes to cut it short;
   // tlast rides on the final byte actually sent.
   task automatic send_packet(input int keep);
      int n;
      n = (keep > 0 && keep < pkt_q.size()) ? keep : pkt_q.size();
      for (int k = 0; k < n; k++) send_byte(pkt_q[k], k == n - 1);
      pkt_q.delete();
   endtask

   // Tag header: prefix, version, random revision and flags, syncsafe size.
   // Bit 7 of each size byte is random since the block must mask it.
   task automatic put_header(input logic [7:0] ver, input logic [27:0] size);
      pkt_q.push_back(PfxByte0);
      pkt_q.push_back(PfxByte1);
      pkt_q.push_back(PfxByte2);
      pkt_q.push_back(ver);
      pkt_q.push_back(8'($urandom));
      pkt_q.push_back(8'($urandom));
      for (int k = 3; k >= 0; k--) pkt_q.push_back({$urandom_range(0, 1) == 1, size[7*k +: 7]});
   endtask

   // Frame header plus len random payload bytes. The size field is coded
   // syncsafe for v2.4 and big-endian for v2.3, independent of len.
   task automatic put_frame(input logic [31:0] id, input logic [31:0] size,
                            input logic v24, input int len);
      for (int k = 3; k >= 0; k--) pkt_q.push_back(id[8*k +: 8]);
      for (int k = 3; k >= 0; k--) begin
         if (v24) pkt_q.push_back({$urandom_range(0, 1) == 1, size[7*k +: 7]});
         else pkt_q.push_back(size[8*k +: 8]);
      end
      pkt_q.push_back(8'($urandom));
      pkt_q.push_back(8'($urandom));
      for (int k = 0; k < len; k++) pkt_q.push_back(8'($urandom));
   endtask

   // Receiver: random stall bursts, one long hold-off so the output buffer
   // fills and req_tready drops, and steady ready in the final stretch.
   initial begin : receiver
      int rx_cycle;
      int stall;
      rx_cycle = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (rx_cycle == HoldStart) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 18);
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run if the stream stops moving.
   initial begin : watchdog
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      int          start;
      int          sel;
      int          nfr;
      int          total;
      int          tag_len;
      int          pad;
      int          keep;
      int          fsz[4];
      logic [31:0] fid[4];
      logic [31:0] fsize[4];
      logic [7:0]  ver;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // --- directed packets ---

      // short packet: a lone prefix byte
      pkt_q.push_back(PfxByte0);
      send_packet(0);

      // bad prefix, all ones in the first byte
      put_header(VerV23, 20);
      pkt_q[0] = 8'hFF;
      send_packet(0);

      // unsupported version, rest of the packet ignored
      put_header(8'h05, 0);
      repeat (3) pkt_q.push_back(8'h00);
      send_packet(0);

      // short packet even though the version is already bad
      put_header(8'hFF, 0);
      send_packet(6);

      // v2.3 walk: every selected kind, an unknown frame with a multi-byte
      // big-endian size, then zero padding that stops on an all-zero ID
      put_header(VerV23, 321);
      put_frame(IdTitle, 3, 1'b0, 3);
      put_frame(IdArtist, 1, 1'b0, 1);
      put_frame(IdStation, 5, 1'b0, 5);
      put_frame(32'h434F_4D4D, 260, 1'b0, 260);
      repeat (12) pkt_q.push_back(8'h00);
      send_packet(0);

      // v2.4 walk with a multi-group syncsafe size; bytes past the tag ignored
      put_header(VerV24, 221);
      put_frame(IdStation, 200, 1'b1, 200);
      put_frame(IdTitle, 1, 1'b1, 1);
      repeat (3) pkt_q.push_back(8'($urandom));
      send_packet(0);

      // zero-size frame stops the walk
      put_header(VerV23, 30);
      put_frame(IdTitle, 0, 1'b0, 0);
      repeat (5) pkt_q.push_back(8'($urandom));
      send_packet(0);

      // frame one byte larger than what is left of the tag
      put_header(VerV23, 20);
      put_frame(IdArtist, 11, 1'b0, 11);
      send_packet(0);

      // frame that fills the tag exactly, payload extremes at both ends
      put_header(VerV24, 20);
      put_frame(IdArtist, 10, 1'b1, 10);
      pkt_q[20] = 8'h00;
      pkt_q[29] = 8'hFF;
      send_packet(0);

      // truncated in the payload, truncated right after the frame header,
      // and a packet that ends inside a frame header
      for (int k = 0; k < 3; k++) begin
         put_header(VerV23, 30);
         put_frame(IdTitle, 8, 1'b0, 8);
         send_packet(k == 0 ? 23 : (k == 1 ? 20 : 15));
      end

      // largest tag size, then a frame whose size bytes are all ones
      put_header(VerV24, 28'hFFF_FFFF);
      put_frame(IdStation, 4, 1'b1, 4);
      put_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 2);
      send_packet(0);

      // tag too small for any frame header
      put_header(VerV23, 9);
      put_frame(IdTitle, 2, 1'b0, 2);
      send_packet(0);

      // --- random packets: mostly well-formed tags, some noise ---
      start = bytes_sent;
      while (bytes_sent - start < RandomBytes) begin
         quiet = (bytes_sent - start >= RandomBytes - QuietBytes);
         sel = $urandom_range(0, 9);
         if (sel == 0) begin
            // noise: random bytes, often starting with a valid prefix byte
            nfr = $urandom_range(1, 14);
            for (int k = 0; k < nfr; k++)
               pkt_q.push_back(($urandom_range(0, 3) == 0) ? PfxByte0 : 8'($urandom));
            send_packet(0);
         end else begin
            ver = (sel == 1) ? 8'($urandom) : (($urandom_range(0, 1) == 1) ? VerV24 : VerV23);
            nfr = $urandom_range(0, 4);
            total = 0;
            for (int f = 0; f < nfr; f++) begin
               fsz[f] = ($urandom_range(0, 15) == 0) ? $urandom_range(16, 140)
                                                     : $urandom_range(1, 12);
               case ($urandom_range(0, 8))
                  0, 1:    fid[f] = IdTitle;
                  2, 3:    fid[f] = IdArtist;
                  4, 5:    fid[f] = IdStation;
                  6, 7:    fid[f] = $urandom;
                  default: fid[f] = '0;
               endcase
               case ($urandom_range(0, 19))
                  0:       fsize[f] = $urandom;
                  1:       fsize[f] = '0;
                  default: fsize[f] = fsz[f];
               endcase
               total += 10 + fsz[f];
            end
            pad = $urandom_range(0, 12);
            tag_len = total + pad;
            if ($urandom_range(0, 9) == 0) begin
               tag_len = total - $urandom_range(1, 5);
               if (tag_len < 0) tag_len = 0;
            end
            put_header(ver, 28'(tag_len));
            for (int f = 0; f < nfr; f++) put_frame(fid[f], fsize[f], ver == VerV24, fsz[f]);
            for (int k = 0; k < pad; k++)
               pkt_q.push_back(($urandom_range(0, 1) == 1) ? 8'h00 : 8'($urandom));
            keep = ($urandom_range(0, 7) == 0) ? $urandom_range(1, pkt_q.size()) : 0;
            send_packet(keep);
         end
      end

      // drop valid, drain every outstanding result, then let the pipe settle
      req_tvalid <= 1'b0;
      while (owed != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (fails == 0 && owed == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
